FILE: hdl/fdt_pkg.sv
// fdt_pkg: shared types and constants for the float to decimal text converter.
// Used by fdt_ctrl, fdt_dp and float_to_decimal_text_top.
`default_nettype none
package fdt_pkg;

  localparam int unsigned CntW      = 7;   // step counter, holds 0..127; the BCD loop counts 0..63
  localparam int unsigned IntDigits = 20;  // decimal digits of a 64-bit value
  localparam int unsigned LeadW     = 5;
  localparam int unsigned ShW       = 7;   // fixed-point shift, 0..99
  localparam int unsigned FixW      = 123; // Q64.59
  localparam int unsigned FracW     = 59;

  localparam logic [7:0]  ExpMin    = 8'd91;   // unbiased -36
  localparam logic [7:0]  ExpOvf    = 8'd191;  // unbiased 64
  localparam logic [63:0] OvfReset  = 64'h0000_0000_FFFF_FFFF;

  localparam logic [6:0] ChMinus = 7'h2D;
  localparam logic [6:0] ChDot   = 7'h2E;
  localparam logic [6:0] ChZero  = 7'h30;

  typedef enum logic [1:0] {
    KIND_SIGN = 2'd0,
    KIND_INT  = 2'd1,
    KIND_DOT  = 2'd2,
    KIND_FRAC = 2'd3
  } kind_e;

  typedef struct packed {
    logic  load;
    logic  frac_step;
    logic  round_init;
    logic  round_step;
    logic  inc;
    logic  dabble;
    logic  emit;
    kind_e kind;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic             neg;
    logic [LeadW-1:0] lead;
    logic             out_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: hdl/fdt_ctrl.sv
// fdt_ctrl: sequencer for the float to decimal text converter.
// Depends on fdt_pkg; drives commands into fdt_dp.
`default_nettype none
module fdt_ctrl #(
  parameter int unsigned FRACTION_DIGITS = 7
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire fdt_pkg::stat_t           stat_i,
  output fdt_pkg::cmd_t                 cmd_o,
  output logic [fdt_pkg::CntW-1:0]      idx_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_FRAC  = 10'b00_0000_0010,
    S_RINIT = 10'b00_0000_0100,
    S_ROUND = 10'b00_0000_1000,
    S_INC   = 10'b00_0001_0000,
    S_BCD   = 10'b00_0010_0000,
    S_SIGN  = 10'b00_0100_0000,
    S_INTD  = 10'b00_1000_0000,
    S_DOT   = 10'b01_0000_0000,
    S_FDIG  = 10'b10_0000_0000
  } state_e;

  localparam logic [fdt_pkg::CntW-1:0] FdCnt   = fdt_pkg::CntW'(FRACTION_DIGITS);
  localparam logic [fdt_pkg::CntW-1:0] FdLast  = fdt_pkg::CntW'(FRACTION_DIGITS - 1);
  localparam logic [fdt_pkg::CntW-1:0] BcdLast = fdt_pkg::CntW'(63);

  state_e                    state_q, state_d;
  logic [fdt_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [fdt_pkg::CntW-1:0]  lead_cnt;

  assign lead_cnt   = fdt_pkg::CntW'(stat_i.lead);
  assign in_stall_o = (state_q != S_IDLE);
  assign idx_o      = cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.kind = fdt_pkg::KIND_SIGN;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_FRAC;
        end
      end
      S_FRAC: begin
        cmd_o.frac_step = 1'b1;
        if (cnt_q == FdCnt) begin
          state_d = S_RINIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_RINIT: begin
        cmd_o.round_init = 1'b1;
        cnt_d            = FdLast;
        state_d          = S_ROUND;
      end
      S_ROUND: begin
        // carry walks from the last kept digit toward the point
        cmd_o.round_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_INC;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_INC: begin
        cmd_o.inc = 1'b1;
        cnt_d     = '0;
        state_d   = S_BCD;
      end
      S_BCD: begin
        cmd_o.dabble = 1'b1;
        if (cnt_q == BcdLast) begin
          state_d = S_SIGN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SIGN: begin
        cmd_o.kind = fdt_pkg::KIND_SIGN;
        if (!stat_i.neg) begin
          cnt_d   = lead_cnt;
          state_d = S_INTD;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cnt_d      = lead_cnt;
          state_d    = S_INTD;
        end
      end
      S_INTD: begin
        cmd_o.kind = fdt_pkg::KIND_INT;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (cnt_q == '0) begin
            state_d = S_DOT;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      S_DOT: begin
        cmd_o.kind = fdt_pkg::KIND_DOT;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cnt_d      = '0;
          state_d    = S_FDIG;
        end
      end
      S_FDIG: begin
        cmd_o.kind = fdt_pkg::KIND_FRAC;
        cmd_o.last = (cnt_q == FdLast);
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (cnt_q == FdLast) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("emit while output register busy");

  a_last_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.last |-> (cmd_o.kind == fdt_pkg::KIND_FRAC))
    else $error("last flag outside fraction digits");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("no return to idle after last beat");

  a_load_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_FRAC && cnt_q == '0))
    else $error("load did not start digit steps");
`endif

endmodule
`default_nettype wire

FILE: hdl/fdt_dp.sv
// fdt_dp: datapath of the float to decimal text converter: fixed-point
// decode, fraction digits, rounding, double dabble and output register.
// Depends on fdt_pkg.
`default_nettype none
module fdt_dp #(
  parameter int unsigned FRACTION_DIGITS = 7
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [31:0]             float_bits_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [63:0]             cfg_wdata_i,
  input  wire fdt_pkg::cmd_t           cmd_i,
  input  wire logic [fdt_pkg::CntW-1:0] idx_i,
  output fdt_pkg::stat_t               stat_o,
  input  wire logic                    out_stall_i,
  output logic                         out_valid_o,
  output logic [6:0]                   text_char_o,
  output logic                         last_char_o
);

  localparam int unsigned NDig = FRACTION_DIGITS + 1;
  localparam int unsigned IdxW = (NDig > 1) ? $clog2(NDig) : 1;

  logic [63:0]              ovf_q;
  logic                     neg_q;
  logic [63:0]              int_q;
  logic [fdt_pkg::FracW-1:0] frac_q;
  logic [3:0]               dig_q [NDig];
  logic                     carry_q;
  logic [3:0]               bcd_q [fdt_pkg::IntDigits];
  logic                     valid_q;
  logic [6:0]               char_q;
  logic                     last_q;

  // decode into Q64.59
  logic [7:0]                exp_b;
  logic [23:0]               mant;
  logic [fdt_pkg::ShW-1:0]   sh;
  logic [fdt_pkg::FixW-1:0]  fix;
  assign exp_b = float_bits_i[30:23];
  assign mant  = {1'b1, float_bits_i[22:0]};
  assign sh    = fdt_pkg::ShW'(exp_b - fdt_pkg::ExpMin);
  assign fix   = fdt_pkg::FixW'(mant) << sh;

  // fraction times ten
  logic [fdt_pkg::FracW+3:0] prod;
  assign prod = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};

  logic [IdxW-1:0] didx;
  assign didx = idx_i[IdxW-1:0];

  logic [3:0] extra;
  logic       up;
  assign extra = dig_q[FRACTION_DIGITS];
  assign up = (extra > 4'd5) ||
              ((extra == 4'd5) && ((frac_q != '0) || dig_q[FRACTION_DIGITS - 1][0]));

  logic [3:0] adj [fdt_pkg::IntDigits];
  always_comb begin
    for (int i = 0; i < fdt_pkg::IntDigits; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  logic [fdt_pkg::LeadW-1:0] lead;
  always_comb begin
    lead = '0;
    for (int i = 0; i < fdt_pkg::IntDigits; i++) begin
      if (bcd_q[i] != 4'd0) lead = fdt_pkg::LeadW'(i);
    end
  end

  logic out_free;
  assign out_free = !valid_q || !out_stall_i;

  assign stat_o.neg      = neg_q;
  assign stat_o.lead     = lead;
  assign stat_o.out_free = out_free;

  logic [6:0] ch;
  always_comb begin
    case (cmd_i.kind)
      fdt_pkg::KIND_SIGN: ch = fdt_pkg::ChMinus;
      fdt_pkg::KIND_INT:  ch = fdt_pkg::ChZero + {3'b000, bcd_q[idx_i[fdt_pkg::LeadW-1:0]]};
      fdt_pkg::KIND_DOT:  ch = fdt_pkg::ChDot;
      fdt_pkg::KIND_FRAC: ch = fdt_pkg::ChZero + {3'b000, dig_q[didx]};
      default:            ch = fdt_pkg::ChDot;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q   <= fdt_pkg::OvfReset;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) ovf_q <= cfg_wdata_i;
      if (cmd_i.emit) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_q <= ch;
      last_q <= cmd_i.last;
    end
    if (cmd_i.load) begin
      neg_q <= float_bits_i[31];
      for (int i = 0; i < NDig; i++) dig_q[i] <= 4'd0;
      if (exp_b < fdt_pkg::ExpMin) begin
        int_q  <= '0;
        frac_q <= '0;
      end else if (exp_b >= fdt_pkg::ExpOvf) begin
        int_q  <= ovf_q;
        frac_q <= '0;
      end else begin
        int_q  <= fix[fdt_pkg::FixW-1:fdt_pkg::FracW];
        frac_q <= fix[fdt_pkg::FracW-1:0];
      end
    end
    if (cmd_i.frac_step) begin
      dig_q[didx] <= prod[fdt_pkg::FracW+3:fdt_pkg::FracW];
      frac_q      <= prod[fdt_pkg::FracW-1:0];
    end
    if (cmd_i.round_init) carry_q <= up;
    if (cmd_i.round_step && carry_q) begin
      if (dig_q[didx] == 4'd9) begin
        dig_q[didx] <= 4'd0;
      end else begin
        dig_q[didx] <= dig_q[didx] + 4'd1;
        carry_q     <= 1'b0;
      end
    end
    if (cmd_i.inc) begin
      int_q <= int_q + {63'd0, carry_q};
      for (int i = 0; i < fdt_pkg::IntDigits; i++) bcd_q[i] <= 4'd0;
    end
    if (cmd_i.dabble) begin
      int_q <= {int_q[62:0], 1'b0};
      bcd_q[0] <= {adj[0][2:0], int_q[63]};
      for (int i = 1; i < fdt_pkg::IntDigits; i++) begin
        bcd_q[i] <= {adj[i][2:0], adj[i-1][3]};
      end
    end
  end

  assign out_valid_o = valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule
`default_nettype wire

FILE: hdl/float_to_decimal_text_top.sv
// float_to_decimal_text_top: one single-precision pattern in, its fixed-point
// decimal text out, one ASCII character per beat, last flag on the final one.
// Steps: load, a digit step per fraction digit plus an extra one, round init, a round
// step per kept digit, carry add, a double-dabble step per integer bit (this loop
// dominates), then one beat per cycle unless stalled; input is held until done.
// Reset (rst_ni low, async) idles the block; overflow integer resets to 0xFFFFFFFF.
`default_nettype none
module float_to_decimal_text_top #(
  parameter int unsigned FRACTION_DIGITS = 7
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] float_bits_i,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [6:0]       text_char_o,
  output logic             last_char_o
);

  fdt_pkg::cmd_t               cmd;
  fdt_pkg::stat_t              stat;
  logic [fdt_pkg::CntW-1:0]    idx;

  fdt_ctrl #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  fdt_dp #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .float_bits_i (float_bits_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .idx_i        (idx),
    .stat_o       (stat),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

endmodule
`default_nettype wire

FILE: tb/sv/fdt_checker.sv
// fdt_checker: watches the float in / text out channels of float_to_decimal_text_top,
// predicts each character and compares. Depends on fdt_pkg for the ASCII codes and OvfReset.
`default_nettype none
module fdt_checker #(
  parameter int unsigned FRACTION_DIGITS = 7
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [31:0] float_bits_i,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [6:0]  text_char_i,
  input  wire logic        last_char_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_beat_t;

  text_beat_t  char_q[$];
  logic [63:0] ovf_int;

  assign pending_o = char_q.size();

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  // render one pattern to text, rounding half to even on an extra digit
  task automatic render_float(input logic [31:0] bits);
    int          e;
    int unsigned fb;
    logic [63:0] mant, ip, frac, fmask;
    logic [3:0]  dig[FRACTION_DIGITS+1];
    logic [3:0]  ibuf[20];
    int          len;
    logic        up, carry;
    text_beat_t  b;
    e = int'(bits[30:23]) - 127;
    mant = {40'd0, 1'b1, bits[22:0]};
    ip = '0; frac = '0; fb = 0;
    foreach (dig[i]) dig[i] = '0;
    if (bits[31]) begin
      b.ch = fdt_pkg::ChMinus; b.last = 1'b0; char_q.push_back(b);
    end
    if (e >= -36) begin
      if (e >= 64) begin
        ip = ovf_int;
      end else if (e >= 23) begin
        ip = mant << (e - 23);
      end else begin
        fb = 23 - e;
        ip = (e >= 0) ? (mant >> fb) : '0;
        frac = mant & ((64'd1 << fb) - 1);
      end
    end
    if (frac != 0) begin
      fmask = (64'd1 << fb) - 1;
      for (int i = 0; i <= FRACTION_DIGITS; i++) begin
        frac = frac * 10;
        dig[i] = 4'(frac >> fb);
        frac &= fmask;
      end
      up = dig[FRACTION_DIGITS] > 5 || (dig[FRACTION_DIGITS] == 5 &&
           (frac != 0 || dig[FRACTION_DIGITS-1][0]));
      if (up) begin
        carry = 1'b1;
        for (int i = FRACTION_DIGITS - 1; i >= 0 && carry; i--) begin
          if (dig[i] == 9) dig[i] = 0;
          else begin dig[i] = dig[i] + 1; carry = 1'b0; end
        end
        if (carry) ip = ip + 1;
      end
    end
    len = 0;
    do begin
      ibuf[len] = 4'(ip % 10);
      ip = ip / 10;
      len++;
    end while (ip != 0);
    for (int i = len - 1; i >= 0; i--) begin
      b.ch = fdt_pkg::ChZero + 7'(ibuf[i]); b.last = 1'b0; char_q.push_back(b);
    end
    b.ch = fdt_pkg::ChDot; b.last = 1'b0; char_q.push_back(b);
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      b.ch = fdt_pkg::ChZero + 7'(dig[i]);
      b.last = (i == FRACTION_DIGITS - 1);
      char_q.push_back(b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    text_beat_t want;
    if (!rst_ni) begin
      ovf_int <= fdt_pkg::OvfReset;
      fail_count_o = 0;
      char_q.delete();
    end else begin
      if (cfg_we_i) ovf_int <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i) render_float(float_bits_i);
      if (out_valid_i && !out_stall_i) begin
        if (char_q.size() == 0) begin
          report($sformatf("unexpected char %h last %b", text_char_i, last_char_i));
        end else begin
          want = char_q.pop_front();
          if (text_char_i !== want.ch)
            report($sformatf("char %h, want %h", text_char_i, want.ch));
          if (last_char_i !== want.last)
            report($sformatf("last %b, want %b", last_char_i, want.last));
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench: drives float patterns and overflow register settings into
// float_to_decimal_text_top; fdt_checker does prediction and comparison.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [31:0] float_bits_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [63:0] cfg_wdata_i = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o, out_valid_o, last_char_o;
  logic [6:0]  text_char_o;
  int          fail_count, pending;
  int          cycles = 0;
  bit          calm = 1'b0;

  float_to_decimal_text_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .float_bits_i,
    .cfg_we_i, .cfg_wdata_i, .out_valid_o, .out_stall_i, .text_char_o, .last_char_o
  );

  fdt_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .float_bits_i,
    .cfg_we_i, .cfg_wdata_i, .out_valid_i(out_valid_o), .out_stall_i,
    .text_char_i(text_char_o), .last_char_i(last_char_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_stall_i <= !calm && ($urandom_range(99) < 24);
    if (cycles > 600000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // valid stays up after an accepted beat; the next call drops it on idle cycles
  task automatic send_float(input logic [31:0] bits);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    float_bits_i <= bits;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_ovf(input logic [63:0] v);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom();
    case ($urandom_range(5))
      0: f[30:23] = 8'($urandom_range(91, 126));     // pure fraction
      1: f[30:23] = 8'($urandom_range(127, 150));    // mixed
      2: f[30:23] = 8'($urandom_range(151, 190));    // large integer
      3: f[30:23] = 8'($urandom_range(115, 135));
      default: ;
    endcase
    return f;
  endfunction

  logic [31:0] directed[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF, 32'h2D80_0000,
    32'h2D7F_FFFF, 32'h3F80_0000, 32'hBF00_0000, 32'h3F7F_FFFF, 32'h4B7F_FFFF,
    32'h5F7F_FFFF, 32'h5F80_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
    32'h7F7F_FFFF, 32'h3DCC_CCCD, 32'h3400_0000, 32'h3380_0000, 32'h3F80_0001,
    32'hC2F6_E979, 32'h3C23_D70A, 32'h4049_0FDB, 32'hFFFF_FFFF, 32'h3456_BF95
  };

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_float(directed[i]);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_ovf('0);
        1: write_ovf(64'hFFFF_FFFF_FFFF_FFFF);
        2: write_ovf({$urandom(), $urandom()});
        default: write_ovf(64'h0000_0000_FFFF_FFFF);
      endcase
      calm = (ph == 2);
      send_float(32'h7F80_0000);
      send_float(32'hDF80_0000);
      for (int i = 0; i < 110; i++) send_float(rand_float());
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
